// File: hw/rtl/nv12_to_rgb_letterbox_unit_defines.svh
// ----------------------------------------------------------------------------
// NV12 to RGB letterbox unit: assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef NV12_TO_RGB_LETTERBOX_UNIT_DEFINES_SVH
`define NV12_TO_RGB_LETTERBOX_UNIT_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define N2R_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication that also covers the reset cycles.
`define N2R_ASSERT_AFTER(name, pre, post, msg) \
  name: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: hw/rtl/n2r_pkg.sv
// ----------------------------------------------------------------------------
// NV12 to RGB letterbox package
// Widths, codes, coefficients and the types shared by the unit's modules.
// ----------------------------------------------------------------------------
package n2r_pkg;

  localparam int MAX_DIMENSION  = 4096;
  localparam int DIM_LIMIT      = (MAX_DIMENSION < 4096) ? MAX_DIMENSION : 4096;
  localparam int DIM_W          = 13;
  localparam int POS_W          = 12;
  localparam int SCALE_W        = 32;
  localparam int SCALE_FRAC     = 16;
  localparam int MX_W           = POS_W + SCALE_W;
  localparam int SXR_W          = MX_W - SCALE_FRAC;
  localparam int PROD_W         = POS_W + DIM_W;
  localparam int AREA_W         = 2 * DIM_W;
  localparam int LUMA_ADDR_W    = 24;
  localparam int CHROMA_ADDR_W  = 25;
  localparam int COEF_FRAC_BITS = 10;
  localparam int ACC_W          = COEF_FRAC_BITS + 13;
  localparam int QUEUE_DEPTH    = 4;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W          = 3;

  localparam logic [7:0] FILL_LEVEL = 8'd114;

  // BT.601 limited-range coefficients, rounded to COEF_FRAC_BITS fraction bits
  localparam logic signed [ACC_W-1:0] COEF_CY =
    ACC_W'(((1164 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [ACC_W-1:0] COEF_RV =
    ACC_W'(((1596 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [ACC_W-1:0] COEF_GU =
    ACC_W'(((391 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [ACC_W-1:0] COEF_GV =
    ACC_W'(((813 << COEF_FRAC_BITS) + 500) / 1000);
  localparam logic signed [ACC_W-1:0] COEF_BU =
    ACC_W'(((2018 << COEF_FRAC_BITS) + 500) / 1000);

  typedef enum logic [IDX_W-1:0] {
    REG_SRC_WIDTH     = 3'd0,
    REG_SRC_HEIGHT    = 3'd1,
    REG_DST_WIDTH     = 3'd2,
    REG_DST_HEIGHT    = 3'd3,
    REG_SCALED_WIDTH  = 3'd4,
    REG_SCALED_HEIGHT = 3'd5,
    REG_INVERSE_SCALE = 3'd6
  } reg_index_t;

  typedef enum logic [1:0] {
    KIND_FILL  = 2'd0,
    KIND_FETCH = 2'd1,
    KIND_PIXEL = 2'd2
  } kind_t;

  localparam logic ACT_STEP    = 1'b0;
  localparam logic ACT_SAMPLES = 1'b1;

  // Destination geometry after clamping
  typedef struct packed {
    logic [DIM_W-1:0] dst_w;
    logic [DIM_W-1:0] dst_h;
    logic [DIM_W-1:0] win_w;
    logic [DIM_W-1:0] win_h;
    logic [POS_W-1:0] pad_x;
    logic [POS_W-1:0] pad_y;
  } geo_t;

  // Source geometry and scale
  typedef struct packed {
    logic [DIM_W-1:0]   src_w;
    logic [DIM_W-1:0]   src_h;
    logic [SCALE_W-1:0] inv;
  } src_t;

  // Classified item handed from the front to the back
  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
    logic [POS_W-1:0] dx;
    logic [POS_W-1:0] dy;
    logic [7:0]       luma;
    logic [7:0]       cb;
    logic [7:0]       cr;
  } cmd_t;

  // Fields that ride along the back pipeline unchanged
  typedef struct packed {
    kind_t            kind;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last;
  } tag_t;

  typedef struct packed {
    kind_t                    kind;
    logic [LUMA_ADDR_W-1:0]   luma_addr;
    logic [CHROMA_ADDR_W-1:0] chroma_addr;
    logic [7:0]               red;
    logic [7:0]               green;
    logic [7:0]               blue;
    logic [POS_W-1:0]         col;
    logic [POS_W-1:0]         row;
    logic                     last;
  } res_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    r = v;
    if (v == '0) r = DIM_W'(1);
    else if (v > DIM_W'(DIM_LIMIT)) r = DIM_W'(DIM_LIMIT);
    return r;
  endfunction

  // Floor shift and saturate to a byte
  function automatic logic [7:0] to_byte(input logic signed [ACC_W-1:0] a);
    logic [ACC_W-1:0] s;
    logic [7:0]       r;
    s = ACC_W'(a) >> COEF_FRAC_BITS;
    if (a[ACC_W-1]) r = 8'd0;
    else if (s > ACC_W'(255)) r = 8'd255;
    else r = s[7:0];
    return r;
  endfunction

endpackage

// File: hw/rtl/nv12_to_rgb_letterbox_unit.sv
// Path: an accepted item passes through the command queue, then a four-stage
//   back pipeline ending in the output register.
// Throughput: one item per cycle; an output stall freezes the back pipeline
//   and the 4-entry command queue takes up to four more items.
// Reset: position and pending-fetch flag cleared, queue and pipeline emptied,
//   registers back to 640, 480, 640, 640, 640, 480 and 1.0 scale.
// ----------------------------------------------------------------------------
// NV12 to RGB letterbox unit
// Raster walk of a letterboxed frame: fill pixels, nearest-neighbour NV12
// fetch requests and BT.601 YUV to RGB conversion.
// ----------------------------------------------------------------------------
`include "nv12_to_rgb_letterbox_unit_defines.svh"

module nv12_to_rgb_letterbox_unit (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [23:0]  s_tdata,   // luma_sample, chroma_u, chroma_v
  input  logic         s_tuser,   // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // luma_address, chroma_address, red, green,
                                  // blue, column, row, zero pad
  output logic [1:0]   m_tuser,   // kind
  output logic         m_tlast,   // frame_end
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  logic [n2r_pkg::DIM_W-1:0]   src_width, src_height, dst_width, dst_height;
  logic [n2r_pkg::DIM_W-1:0]   scaled_width, scaled_height;
  logic [n2r_pkg::SCALE_W-1:0] inverse_scale;

  n2r_pkg::geo_t geo;
  n2r_pkg::src_t src;
  n2r_pkg::cmd_t push_cmd, head_cmd;
  n2r_pkg::res_t res;
  logic          push, q_full, q_pop, q_valid;
  logic [n2r_pkg::DIM_W-1:0] dw, dh;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      src_width     <= n2r_pkg::DIM_W'(640);
      src_height    <= n2r_pkg::DIM_W'(480);
      dst_width     <= n2r_pkg::DIM_W'(640);
      dst_height    <= n2r_pkg::DIM_W'(640);
      scaled_width  <= n2r_pkg::DIM_W'(640);
      scaled_height <= n2r_pkg::DIM_W'(480);
      inverse_scale <= n2r_pkg::SCALE_W'(65536);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        n2r_pkg::REG_SRC_WIDTH:     src_width     <= cfg_data[n2r_pkg::DIM_W-1:0];
        n2r_pkg::REG_SRC_HEIGHT:    src_height    <= cfg_data[n2r_pkg::DIM_W-1:0];
        n2r_pkg::REG_DST_WIDTH:     dst_width     <= cfg_data[n2r_pkg::DIM_W-1:0];
        n2r_pkg::REG_DST_HEIGHT:    dst_height    <= cfg_data[n2r_pkg::DIM_W-1:0];
        n2r_pkg::REG_SCALED_WIDTH:  scaled_width  <= cfg_data[n2r_pkg::DIM_W-1:0];
        n2r_pkg::REG_SCALED_HEIGHT: scaled_height <= cfg_data[n2r_pkg::DIM_W-1:0];
        n2r_pkg::REG_INVERSE_SCALE: inverse_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp sizes and center the window
  always_comb begin
    dw        = n2r_pkg::clamp_dim(dst_width);
    dh        = n2r_pkg::clamp_dim(dst_height);
    geo.dst_w = dw;
    geo.dst_h = dh;
    geo.win_w = (scaled_width > dw) ? dw : scaled_width;
    geo.win_h = (scaled_height > dh) ? dh : scaled_height;
    geo.pad_x = n2r_pkg::POS_W'((dw - geo.win_w) >> 1);
    geo.pad_y = n2r_pkg::POS_W'((dh - geo.win_h) >> 1);
    src.src_w = n2r_pkg::clamp_dim(src_width);
    src.src_h = n2r_pkg::clamp_dim(src_height);
    src.inv   = inverse_scale;
  end

  n2r_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_action (s_tuser),
    .in_luma   (s_tdata[7:0]),
    .in_cb     (s_tdata[15:8]),
    .in_cr     (s_tdata[23:16]),
    .geo       (geo),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  n2r_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (head_cmd)
  );

  n2r_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .cmd       (head_cmd),
    .src       (src),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {7'd0, res.row, res.col, res.blue, res.green, res.red,
                    res.chroma_addr, res.luma_addr};
  assign m_tuser = res.kind;
  assign m_tlast = res.last;

  `N2R_ASSERT_NOW(a_fetch_not_last,
    m_tvalid && (m_tuser == n2r_pkg::KIND_FETCH), !m_tlast,
    "fetch request marked as frame end")
  `N2R_ASSERT_NOW(a_pixel_no_address,
    m_tvalid && (m_tuser != n2r_pkg::KIND_FETCH), m_tdata[48:0] == '0,
    "pixel result carries a nonzero address")
  `N2R_ASSERT_NOW(a_fill_gray,
    m_tvalid && (m_tuser == n2r_pkg::KIND_FILL),
    (m_tdata[56:49] == n2r_pkg::FILL_LEVEL) && (m_tdata[64:57] == n2r_pkg::FILL_LEVEL) &&
    (m_tdata[72:65] == n2r_pkg::FILL_LEVEL),
    "fill pixel is not gray")
  `N2R_ASSERT_AFTER(a_reset_empty, rst, !m_tvalid && s_tready,
    "reset did not empty the queue and pipeline")

endmodule

// File: hw/rtl/n2r_front.sv
// ----------------------------------------------------------------------------
// NV12 to RGB letterbox front end
// Holds the raster position, classifies each item and queues a command for every item but dropped samples.
// ----------------------------------------------------------------------------
module n2r_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_action,
  input  logic [7:0]                in_luma,
  input  logic [7:0]                in_cb,
  input  logic [7:0]                in_cr,
  input  n2r_pkg::geo_t             geo,
  input  logic                      q_full,
  output logic                      push,
  output n2r_pkg::cmd_t             cmd
);

  logic [n2r_pkg::POS_W-1:0] col, col_next;
  logic [n2r_pkg::POS_W-1:0] row, row_next;
  logic                      awaiting, awaiting_next;

  logic [n2r_pkg::DIM_W-1:0] col_inc, row_inc, win_x_end, win_y_end;
  logic                      col_wrap, row_wrap, in_win, samples, accept, advance;

  always_comb begin
    col_inc   = {1'b0, col} + n2r_pkg::DIM_W'(1);
    row_inc   = {1'b0, row} + n2r_pkg::DIM_W'(1);
    col_wrap  = col_inc >= geo.dst_w;
    row_wrap  = row_inc >= geo.dst_h;
    win_x_end = {1'b0, geo.pad_x} + geo.win_w;
    win_y_end = {1'b0, geo.pad_y} + geo.win_h;
    in_win    = (col >= geo.pad_x) && ({1'b0, col} < win_x_end) &&
                (row >= geo.pad_y) && ({1'b0, row} < win_y_end);
    samples   = in_action == n2r_pkg::ACT_SAMPLES;
    in_ready  = !q_full;
    accept    = in_valid && in_ready;

    // Samples with no fetch outstanding are dropped
    push      = accept && (!samples || awaiting);
    advance   = accept && (samples ? awaiting : !(in_win || awaiting));

    cmd.col  = col;
    cmd.row  = row;
    cmd.dx   = (col >= geo.pad_x) ? col - geo.pad_x : '0;
    cmd.dy   = (row >= geo.pad_y) ? row - geo.pad_y : '0;
    cmd.luma = in_luma;
    cmd.cb   = in_cb;
    cmd.cr   = in_cr;
    if (samples) begin
      cmd.kind = n2r_pkg::KIND_PIXEL;
      cmd.last = col_wrap && row_wrap;
    end else if (in_win || awaiting) begin
      cmd.kind = n2r_pkg::KIND_FETCH;
      cmd.last = 1'b0;
    end else begin
      cmd.kind = n2r_pkg::KIND_FILL;
      cmd.last = col_wrap && row_wrap;
    end

    col_next      = col;
    row_next      = row;
    awaiting_next = awaiting;
    if (accept) begin
      if (samples) awaiting_next = 1'b0;
      else if (in_win || awaiting) awaiting_next = 1'b1;
    end
    if (advance) begin
      if (col_wrap) begin
        col_next = '0;
        row_next = row_wrap ? '0 : row_inc[n2r_pkg::POS_W-1:0];
      end else begin
        col_next = col_inc[n2r_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      awaiting <= 1'b0;
    end else begin
      col      <= col_next;
      row      <= row_next;
      awaiting <= awaiting_next;
    end
  end

endmodule

// File: hw/rtl/n2r_queue.sv
// ----------------------------------------------------------------------------
// NV12 to RGB letterbox command queue
// Short FIFO that decouples the front end from the back pipeline.
// ----------------------------------------------------------------------------
module n2r_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  n2r_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output n2r_pkg::cmd_t head
);

  n2r_pkg::cmd_t              entries [n2r_pkg::QUEUE_DEPTH];
  logic [n2r_pkg::QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [n2r_pkg::QCNT_W-1:0] count;
  logic                       do_push, do_pop;

  always_comb begin
    full      = count == n2r_pkg::QCNT_W'(n2r_pkg::QUEUE_DEPTH);
    not_empty = count != '0;
    do_push   = push && !full;
    do_pop    = pop && not_empty;
    head      = entries[rd_ptr];
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + n2r_pkg::QPTR_W'(1);
      if (do_pop) rd_ptr <= rd_ptr + n2r_pkg::QPTR_W'(1);
      if (do_push && !do_pop) count <= count + n2r_pkg::QCNT_W'(1);
      else if (do_pop && !do_push) count <= count - n2r_pkg::QCNT_W'(1);
    end
  end

endmodule

// File: hw/rtl/n2r_back.sv
// ----------------------------------------------------------------------------
// NV12 to RGB letterbox back end
// Four-stage pipeline: scale products and color terms, clamp and saturate,
// address products, final sums into the output register.
// ----------------------------------------------------------------------------
module n2r_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          q_valid,
  output logic          q_pop,
  input  n2r_pkg::cmd_t cmd,
  input  n2r_pkg::src_t src,
  output logic          out_valid,
  input  logic          out_ready,
  output n2r_pkg::res_t res
);

  logic                               en;
  logic signed [9:0]                  y_off, u_off, v_off;

  // stage 1
  logic                               v1;
  n2r_pkg::tag_t                      t1;
  logic [n2r_pkg::MX_W-1:0]           mx1, my1;
  logic signed [n2r_pkg::ACC_W-1:0]   cy1, rv1, gu1, gv1, bu1;

  // stage 2
  logic                               v2;
  n2r_pkg::tag_t                      t2;
  logic [n2r_pkg::POS_W-1:0]          sx2, sy2;
  logic [7:0]                         r2, g2, b2;
  logic [n2r_pkg::SXR_W-1:0]          sx_raw, sy_raw;
  logic [n2r_pkg::DIM_W-1:0]          lim_x, lim_y;
  logic signed [n2r_pkg::ACC_W-1:0]   acc_r, acc_g, acc_b;

  // stage 3
  logic                               v3;
  n2r_pkg::tag_t                      t3;
  logic [n2r_pkg::POS_W-1:0]          sx3;
  logic [n2r_pkg::PROD_W-1:0]         lp3, cp3;
  logic [n2r_pkg::AREA_W-1:0]         ar3;
  logic [7:0]                         r3, g3, b3;
  logic [n2r_pkg::PROD_W-1:0]         luma_sum;
  logic [n2r_pkg::AREA_W-1:0]         chroma_sum;

  always_comb begin
    // the whole pipeline holds while the output register is stalled
    en    = !out_valid || out_ready;
    q_pop = en && q_valid;
    y_off = $signed({2'b00, cmd.luma}) - 10'sd16;
    u_off = $signed({2'b00, cmd.cb}) - 10'sd128;
    v_off = $signed({2'b00, cmd.cr}) - 10'sd128;

    sx_raw = mx1[n2r_pkg::MX_W-1:n2r_pkg::SCALE_FRAC];
    sy_raw = my1[n2r_pkg::MX_W-1:n2r_pkg::SCALE_FRAC];
    lim_x  = src.src_w - n2r_pkg::DIM_W'(1);
    lim_y  = src.src_h - n2r_pkg::DIM_W'(1);
    acc_r  = cy1 + rv1;
    acc_g  = cy1 - gu1 - gv1;
    acc_b  = cy1 + bu1;

    luma_sum   = lp3 + n2r_pkg::PROD_W'(sx3);
    chroma_sum = ar3 + n2r_pkg::AREA_W'(cp3) +
                 n2r_pkg::AREA_W'({sx3[n2r_pkg::POS_W-1:1], 1'b0});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= q_valid;
      v2        <= v1;
      v3        <= v2;
      out_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1.kind <= cmd.kind;
      t1.col  <= cmd.col;
      t1.row  <= cmd.row;
      t1.last <= cmd.last;
      mx1     <= cmd.dx * src.inv;
      my1     <= cmd.dy * src.inv;
      cy1     <= y_off * n2r_pkg::COEF_CY;
      rv1     <= v_off * n2r_pkg::COEF_RV;
      gu1     <= u_off * n2r_pkg::COEF_GU;
      gv1     <= v_off * n2r_pkg::COEF_GV;
      bu1     <= u_off * n2r_pkg::COEF_BU;

      t2  <= t1;
      sx2 <= (sx_raw > n2r_pkg::SXR_W'(lim_x)) ? lim_x[n2r_pkg::POS_W-1:0]
                                                : sx_raw[n2r_pkg::POS_W-1:0];
      sy2 <= (sy_raw > n2r_pkg::SXR_W'(lim_y)) ? lim_y[n2r_pkg::POS_W-1:0]
                                                : sy_raw[n2r_pkg::POS_W-1:0];
      r2  <= n2r_pkg::to_byte(acc_r);
      g2  <= n2r_pkg::to_byte(acc_g);
      b2  <= n2r_pkg::to_byte(acc_b);

      t3  <= t2;
      sx3 <= sx2;
      lp3 <= sy2 * src.src_w;
      cp3 <= (sy2 >> 1) * src.src_w;
      ar3 <= src.src_w * src.src_h;
      r3  <= r2;
      g3  <= g2;
      b3  <= b2;

      res.kind        <= t3.kind;
      res.col         <= t3.col;
      res.row         <= t3.row;
      res.last        <= t3.last;
      res.luma_addr   <= '0;
      res.chroma_addr <= '0;
      res.red         <= '0;
      res.green       <= '0;
      res.blue        <= '0;
      case (t3.kind)
        n2r_pkg::KIND_FETCH: begin
          res.luma_addr   <= luma_sum[n2r_pkg::LUMA_ADDR_W-1:0];
          res.chroma_addr <= chroma_sum[n2r_pkg::CHROMA_ADDR_W-1:0];
        end
        n2r_pkg::KIND_PIXEL: begin
          res.red   <= r3;
          res.green <= g3;
          res.blue  <= b3;
        end
        default: begin
          res.red   <= n2r_pkg::FILL_LEVEL;
          res.green <= n2r_pkg::FILL_LEVEL;
          res.blue  <= n2r_pkg::FILL_LEVEL;
        end
      endcase
    end
  end

endmodule
